### rtl/usm_pkg.sv
// shared types, constants and cordic table for the uv sphere mesh generator
package usm_pkg;

  localparam int CFG_W           = 9;
  localparam int ITEM_W          = 17;
  localparam int IDX_W           = 16;
  localparam int COORD_W         = 16;
  localparam int MIN_LINES       = 3;
  localparam int MAX_LAT         = 256;
  localparam int MAX_LONG        = 256;
  localparam int LAT_RESET       = 10;
  localparam int LONG_RESET      = 10;
  localparam int COORD_FRAC_BITS = 14;

  // angles in q16 radians
  localparam int ANG_W        = 19;
  localparam int ANG_P_STEP   = 411566;  // 2 * 3.14
  localparam int ANG_Y_STEP   = 823132;  // 2 * 6.28
  localparam int ANG_PI       = 205887;
  localparam int ANG_HALF_PI  = 102944;
  localparam int ANG_3HALF_PI = 308831;
  localparam int ANG_2PI      = 411775;

  // cordic
  localparam int ZW           = 20;
  localparam int CW           = 32;
  localparam int CORDIC_K     = 652032874;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_SPS   = 2;
  localparam int CORDIC_LAT   = CORDIC_STEPS / CORDIC_SPS + 1;
  localparam int ATAN_Q16 [CORDIC_STEPS] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef enum logic {
    OP_VERTEX   = 1'b0,
    OP_TRIANGLE = 1'b1
  } op_t;

  typedef enum logic {
    CFG_LAT_LINES  = 1'b0,
    CFG_LONG_LINES = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              operation;
    logic [ITEM_W-1:0] item_number;
  } req_t;

  typedef struct packed {
    logic                      status;
    logic [IDX_W-1:0]          index_a;
    logic [IDX_W-1:0]          index_b;
    logic [IDX_W-1:0]          index_c;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } rsp_t;

endpackage

### rtl/usm_cordic.sv
// pipelined cordic: sine and cosine of a q16 angle in [0, 2pi), q30 results
module usm_cordic (
  input  logic                           clk,
  input  logic                           en,
  input  logic [usm_pkg::ANG_W-1:0]      angle,
  output logic signed [usm_pkg::CW-1:0]  sin_v,
  output logic signed [usm_pkg::CW-1:0]  cos_v
);
  import usm_pkg::*;

  localparam int NST = CORDIC_STEPS / CORDIC_SPS;

  logic signed [ZW-1:0] a_ext;
  logic signed [ZW-1:0] z0_next;
  logic                 neg0_next;

  logic signed [CW-1:0] xs  [1:NST];
  logic signed [CW-1:0] ys  [1:NST];
  logic signed [ZW-1:0] zs  [0:NST-1];
  logic                 ng  [0:NST];
  logic signed [CW-1:0] xin [1:NST];
  logic signed [CW-1:0] yin [1:NST];
  logic signed [CW-1:0] xn  [1:NST];
  logic signed [CW-1:0] yn  [1:NST];
  logic signed [ZW-1:0] zn  [1:NST];

  // quadrant folding into [-pi/2, pi/2]
  always_comb begin
    a_ext     = $signed({1'b0, angle});
    neg0_next = 1'b0;
    if (a_ext > ZW'(ANG_HALF_PI) && a_ext <= ZW'(ANG_3HALF_PI)) begin
      z0_next   = ZW'(ANG_PI) - a_ext;
      neg0_next = 1'b1;
    end else if (a_ext > ZW'(ANG_3HALF_PI)) begin
      z0_next = a_ext - ZW'(ANG_2PI);
    end else begin
      z0_next = a_ext;
    end
  end

  always_comb begin
    xin[1] = CW'(CORDIC_K);
    yin[1] = '0;
    for (int k = 2; k <= NST; k++) begin
      xin[k] = xs[k-1];
      yin[k] = ys[k-1];
    end
  end

  always_comb begin
    logic signed [CW-1:0] tx, ty, dx, dy;
    logic signed [ZW-1:0] tz;
    for (int k = 1; k <= NST; k++) begin
      tx = xin[k];
      ty = yin[k];
      tz = zs[k-1];
      for (int j = 0; j < CORDIC_SPS; j++) begin
        dx = ty >>> ((k-1)*CORDIC_SPS + j);
        dy = tx >>> ((k-1)*CORDIC_SPS + j);
        if (tz >= 0) begin
          tx = tx - dx;
          ty = ty + dy;
          tz = tz - ZW'(ATAN_Q16[(k-1)*CORDIC_SPS + j]);
        end else begin
          tx = tx + dx;
          ty = ty - dy;
          tz = tz + ZW'(ATAN_Q16[(k-1)*CORDIC_SPS + j]);
        end
      end
      xn[k] = tx;
      yn[k] = ty;
      zn[k] = tz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zs[0] <= z0_next;
      ng[0] <= neg0_next;
      for (int k = 1; k <= NST; k++) begin
        xs[k] <= xn[k];
        ys[k] <= yn[k];
        ng[k] <= ng[k-1];
      end
      for (int k = 1; k < NST; k++) begin
        zs[k] <= zn[k];
      end
    end
  end

  assign sin_v = ys[NST];
  assign cos_v = ng[NST] ? -xs[NST] : xs[NST];

endmodule

### rtl/uv_sphere_mesh_generator.sv
// top level: uv sphere vertex position and triangle index pipeline
// path: request register, divider 1, divider 2, cordic stages, products, output register
// throughput: one request per cycle; every stage advances together whenever the
//   output register is empty or its beat is being taken
// reset (rst, synchronous): clears all stage valid bits, sets lat_lines and
//   long_lines to 10; no clearing pass, requests are taken right after reset
module uv_sphere_mesh_generator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  usm_pkg::cfg_reg_t           cfg_index,
  input  logic [usm_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  usm_pkg::req_t               req_data,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output usm_pkg::rsp_t               rsp_data
);
  import usm_pkg::*;

  // first divider: ring/column or band/remainder, 8 quotient bits
  localparam int D1_Q   = 8;
  localparam int D1_RW  = 10;
  localparam int D1_W   = D1_RW + D1_Q;
  localparam int D1_SPS = 2;
  localparam int D1_ST  = D1_Q / D1_SPS;
  // second dividers: rounded angles, 19 quotient bits
  localparam int D2_Q   = ANG_W;
  localparam int D2_RW  = 10;
  localparam int D2_W   = D2_RW + D2_Q;
  localparam int NUM_W  = D2_W - 1;
  localparam int D2_SPS = 4;
  localparam int D2_ST  = (D2_Q + D2_SPS - 1) / D2_SPS;
  localparam int PROD_W = 2 * CW;

  // per-item control and triangle result traveling down the pipe
  typedef struct packed {
    logic             op;
    logic             err;
    logic             pole_n;
    logic             pole_s;
    logic             band;
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    logic [IDX_W-1:0] ic;
  } side_t;

  function automatic logic [D1_W-1:0] d1_step(input logic [D1_W-1:0] t,
                                               input logic [D1_RW-1:0] d);
    logic [D1_RW:0] tr;
    logic           qb;
    tr = {t[D1_W-1:D1_Q], t[D1_Q-1]};
    qb = (tr >= {1'b0, d});
    if (qb) tr = tr - {1'b0, d};
    return {tr[D1_RW-1:0], t[D1_Q-2:0], qb};
  endfunction

  function automatic logic [D2_W-1:0] d2_step(input logic [D2_W-1:0] t,
                                               input logic [D2_RW-1:0] d);
    logic [D2_RW:0] tr;
    logic           qb;
    tr = {t[D2_W-1:D2_Q], t[D2_Q-1]};
    qb = (tr >= {1'b0, d});
    if (qb) tr = tr - {1'b0, d};
    return {tr[D2_RW-1:0], t[D2_Q-2:0], qb};
  endfunction

  // round half up by sh bits, saturate to +-1.0, keep 16 bits
  function automatic logic [COORD_W-1:0] to_coord(input logic signed [PROD_W-1:0] v,
                                                  input int sh);
    logic signed [PROD_W-1:0] t;
    logic signed [PROD_W-1:0] lim;
    lim = PROD_W'(1) <<< COORD_FRAC_BITS;
    t   = (v + (PROD_W'(1) <<< (sh - 1))) >>> sh;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return t[COORD_W-1:0];
  endfunction

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] lat_lines, long_lines;
  logic [CFG_W-1:0] lat_c, lg_c;
  logic [CFG_W-1:0] lat_e, lg_e;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [ITEM_W-1:0] nv, nt, band_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_lines  <= CFG_W'(LAT_RESET);
      long_lines <= CFG_W'(LONG_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LAT_LINES:  lat_lines  <= cfg_data;
        CFG_LONG_LINES: long_lines <= cfg_data;
      endcase
    end
  end

  // clamped line counts and ring vertex total, registered behind the config
  // registers; a request reads them only from its second stage on
  always_comb begin
    lat_c = (lat_lines < CFG_W'(MIN_LINES)) ? CFG_W'(MIN_LINES) :
            (lat_lines > CFG_W'(MAX_LAT))   ? CFG_W'(MAX_LAT)   : lat_lines;
    lg_c  = (long_lines < CFG_W'(MIN_LINES)) ? CFG_W'(MIN_LINES) :
            (long_lines > CFG_W'(MAX_LONG))  ? CFG_W'(MAX_LONG)  : long_lines;
    cnt_next = IDX_W'((ITEM_W'(lat_c) - ITEM_W'(2)) * ITEM_W'(lg_c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_e <= CFG_W'(LAT_RESET);
      lg_e  <= CFG_W'(LONG_RESET);
      cnt   <= IDX_W'((LAT_RESET - 2) * LONG_RESET);
    end else begin
      lat_e <= lat_c;
      lg_e  <= lg_c;
      cnt   <= cnt_next;
    end
  end

  assign nv       = {1'b0, cnt} + ITEM_W'(2);   // vertex count
  assign nt       = {cnt, 1'b0};                // triangle count
  assign band_end = nt - ITEM_W'(lg_e);         // first bottom cap triangle

  // ---------------- flow control ----------------
  // whole pipe moves when the output register can take a new beat
  logic move;
  assign move      = !rsp_valid || !rsp_stall;
  assign req_stall = !move;

  // ---------------- stage 0: request register ----------------
  logic v0;
  req_t r0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (move) v0 <= req_valid;
  end

  always_ff @(posedge clk) begin
    if (move) r0 <= req_data;
  end

  // ---------------- stage 1: decode, range check, cap fans ----------------
  side_t             sd1n;
  logic [D1_W-1:0]   rq1n;
  logic [D1_RW-1:0]  dv1n;

  always_comb begin
    logic [ITEM_W-1:0] item, dvd, l;
    item = r0.item_number;
    l    = item - band_end;
    sd1n = '0;
    sd1n.op = r0.operation;
    if (r0.operation == OP_VERTEX) begin
      sd1n.err    = (item >= nv);
      sd1n.pole_n = (item == '0);
      sd1n.pole_s = (item == nv - ITEM_W'(1));
      dvd  = item - ITEM_W'(1);
      dv1n = {1'b0, lg_e};
    end else begin
      sd1n.err = (item >= nt);
      dvd  = item - ITEM_W'(lg_e);
      dv1n = {lg_e, 1'b0};
      if (item < ITEM_W'(lg_e)) begin
        // top cap fan around the north pole
        if (item < ITEM_W'(lg_e) - ITEM_W'(1)) begin
          sd1n.ib = IDX_W'(item + ITEM_W'(1));
          sd1n.ic = IDX_W'(item + ITEM_W'(2));
        end else begin
          sd1n.ib = IDX_W'(lg_e);
          sd1n.ic = IDX_W'(1);
        end
      end else if (item < band_end) begin
        sd1n.band = 1'b1;
      end else begin
        // bottom cap fan around the south pole
        sd1n.ia = IDX_W'(nv - ITEM_W'(1));
        if (l < ITEM_W'(lg_e) - ITEM_W'(1)) begin
          sd1n.ib = IDX_W'(nv - ITEM_W'(2) - l);
          sd1n.ic = IDX_W'(nv - ITEM_W'(3) - l);
        end else begin
          sd1n.ib = IDX_W'(nv - ITEM_W'(1) - ITEM_W'(lg_e));
          sd1n.ic = IDX_W'(nv - ITEM_W'(2));
        end
      end
    end
    // quotient fits 8 bits, so the top dividend bits seed the remainder
    rq1n = {1'b0, dvd};
  end

  // ---------------- divider 1: 2 quotient bits per stage ----------------
  logic              v_d1  [0:D1_ST];
  side_t             sd_d1 [0:D1_ST];
  logic [D1_W-1:0]   rq_d1 [0:D1_ST];
  logic [D1_RW-1:0]  dv_d1 [0:D1_ST-1];
  logic [D1_W-1:0]   rq_d1n [1:D1_ST];

  always_comb begin
    logic [D1_W-1:0] t;
    for (int k = 1; k <= D1_ST; k++) begin
      t = rq_d1[k-1];
      for (int j = 0; j < D1_SPS; j++) begin
        t = d1_step(t, dv_d1[k-1]);
      end
      rq_d1n[k] = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= D1_ST; k++) v_d1[k] <= 1'b0;
    end else if (move) begin
      v_d1[0] <= v0;
      for (int k = 1; k <= D1_ST; k++) v_d1[k] <= v_d1[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      sd_d1[0] <= sd1n;
      rq_d1[0] <= rq1n;
      dv_d1[0] <= dv1n;
      for (int k = 1; k <= D1_ST; k++) begin
        sd_d1[k] <= sd_d1[k-1];
        rq_d1[k] <= rq_d1n[k];
      end
      for (int k = 1; k < D1_ST; k++) dv_d1[k] <= dv_d1[k-1];
    end
  end

  // ---------------- band quads and angle numerators ----------------
  side_t             sdmn;
  logic [NUM_W-1:0]  npn, nyn;
  logic [D2_RW-1:0]  dvpn, dvyn;

  always_comb begin
    logic [D1_Q-1:0]   q;
    logic [D1_RW-1:0]  rm;
    logic [CFG_W-1:0]  col;
    logic [ITEM_W-1:0] top, bot, t0, t1, b0, b1;
    q    = rq_d1[D1_ST][D1_Q-1:0];
    rm   = rq_d1[D1_ST][D1_W-1:D1_Q];
    col  = rm[D1_RW-1:1];
    top  = ITEM_W'(q) * ITEM_W'(lg_e);
    bot  = top + ITEM_W'(lg_e);
    t0   = top + ITEM_W'(col) + ITEM_W'(1);
    b0   = bot + ITEM_W'(col) + ITEM_W'(1);
    // last column wraps back to the first
    if (col < lg_e - CFG_W'(1)) begin
      t1 = top + ITEM_W'(col) + ITEM_W'(2);
      b1 = bot + ITEM_W'(col) + ITEM_W'(2);
    end else begin
      t1 = top + ITEM_W'(1);
      b1 = bot + ITEM_W'(1);
    end
    sdmn = sd_d1[D1_ST];
    if (sdmn.op == OP_TRIANGLE && sdmn.band) begin
      if (!rm[0]) begin
        sdmn.ia = IDX_W'(t0);
        sdmn.ib = IDX_W'(t1);
        sdmn.ic = IDX_W'(b0);
      end else begin
        sdmn.ia = IDX_W'(b0);
        sdmn.ib = IDX_W'(t1);
        sdmn.ic = IDX_W'(b1);
      end
    end
    // vertex: ring = q, column = remainder; +divisor/2 gives round half up
    npn  = (NUM_W'(q) + NUM_W'(1)) * NUM_W'(ANG_P_STEP) + NUM_W'(lat_e) - NUM_W'(1);
    nyn  = NUM_W'(rm[CFG_W-1:0]) * NUM_W'(ANG_Y_STEP) + NUM_W'(lg_e);
    dvpn = {lat_e - CFG_W'(1), 1'b0};
    dvyn = {lg_e, 1'b0};
  end

  // ---------------- divider 2 (pitch and yaw): 4 bits per stage ----------------
  logic              v_d2   [0:D2_ST];
  side_t             sd_d2  [0:D2_ST];
  logic [D2_W-1:0]   rqp_d2 [0:D2_ST];
  logic [D2_W-1:0]   rqy_d2 [0:D2_ST];
  logic [D2_RW-1:0]  dvp_d2 [0:D2_ST-1];
  logic [D2_RW-1:0]  dvy_d2 [0:D2_ST-1];
  logic [D2_W-1:0]   rqp_n  [1:D2_ST];
  logic [D2_W-1:0]   rqy_n  [1:D2_ST];

  always_comb begin
    logic [D2_W-1:0] tp, ty;
    for (int k = 1; k <= D2_ST; k++) begin
      tp = rqp_d2[k-1];
      ty = rqy_d2[k-1];
      for (int j = 0; j < D2_SPS; j++) begin
        if ((k-1)*D2_SPS + j < D2_Q) begin
          tp = d2_step(tp, dvp_d2[k-1]);
          ty = d2_step(ty, dvy_d2[k-1]);
        end
      end
      rqp_n[k] = tp;
      rqy_n[k] = ty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= D2_ST; k++) v_d2[k] <= 1'b0;
    end else if (move) begin
      v_d2[0] <= v_d1[D1_ST];
      for (int k = 1; k <= D2_ST; k++) v_d2[k] <= v_d2[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      sd_d2[0]  <= sdmn;
      rqp_d2[0] <= {1'b0, npn};
      rqy_d2[0] <= {1'b0, nyn};
      dvp_d2[0] <= dvpn;
      dvy_d2[0] <= dvyn;
      for (int k = 1; k <= D2_ST; k++) begin
        sd_d2[k]  <= sd_d2[k-1];
        rqp_d2[k] <= rqp_n[k];
        rqy_d2[k] <= rqy_n[k];
      end
      for (int k = 1; k < D2_ST; k++) begin
        dvp_d2[k] <= dvp_d2[k-1];
        dvy_d2[k] <= dvy_d2[k-1];
      end
    end
  end

  // ---------------- sine / cosine ----------------
  logic signed [CW-1:0] sp, cp, sy, cy;

  usm_cordic u_cordic_p (
    .clk   (clk),
    .en    (move),
    .angle (rqp_d2[D2_ST][D2_Q-1:0]),
    .sin_v (sp),
    .cos_v (cp)
  );

  usm_cordic u_cordic_y (
    .clk   (clk),
    .en    (move),
    .angle (rqy_d2[D2_ST][D2_Q-1:0]),
    .sin_v (sy),
    .cos_v (cy)
  );

  // control rides alongside the cordic stages
  logic  v_c  [1:CORDIC_LAT];
  side_t sd_c [1:CORDIC_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= CORDIC_LAT; k++) v_c[k] <= 1'b0;
    end else if (move) begin
      v_c[1] <= v_d2[D2_ST];
      for (int k = 2; k <= CORDIC_LAT; k++) v_c[k] <= v_c[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      sd_c[1] <= sd_d2[D2_ST];
      for (int k = 2; k <= CORDIC_LAT; k++) sd_c[k] <= sd_c[k-1];
    end
  end

  // ---------------- products ----------------
  logic                     v_x;
  side_t                    sd_x;
  logic signed [PROD_W-1:0] px, py;
  logic signed [CW-1:0]     cz;

  always_ff @(posedge clk) begin
    if (rst) v_x <= 1'b0;
    else if (move) v_x <= v_c[CORDIC_LAT];
  end

  always_ff @(posedge clk) begin
    if (move) begin
      sd_x <= sd_c[CORDIC_LAT];
      px   <= sp * sy;
      py   <= -(sp * cy);
      cz   <= cp;
    end
  end

  // ---------------- output rounding and register ----------------
  rsp_t rsp_next;

  always_comb begin
    rsp_next = '0;
    if (sd_x.err) begin
      rsp_next.status = 1'b1;
    end else if (sd_x.op == OP_VERTEX) begin
      if (sd_x.pole_n) begin
        rsp_next.pos_z = COORD_W'(1 << COORD_FRAC_BITS);
      end else if (sd_x.pole_s) begin
        rsp_next.pos_z = COORD_W'(-(1 << COORD_FRAC_BITS));
      end else begin
        rsp_next.pos_x = to_coord(px, 2*(CW-2) - COORD_FRAC_BITS);
        rsp_next.pos_y = to_coord(py, 2*(CW-2) - COORD_FRAC_BITS);
        rsp_next.pos_z = to_coord(PROD_W'(cz), (CW-2) - COORD_FRAC_BITS);
      end
    end else begin
      rsp_next.index_a = sd_x.ia;
      rsp_next.index_b = sd_x.ib;
      rsp_next.index_c = sd_x.ic;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (move) rsp_valid <= v_x;
  end

  always_ff @(posedge clk) begin
    if (move) rsp_data <= rsp_next;
  end

endmodule

### test/uv_sphere_mesh_generator_tb.sv
// testbench for the uv sphere mesh generator: vertex and triangle queries against a predictor
module uv_sphere_mesh_generator_tb;
  import usm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_write = 1'b0;
  cfg_reg_t cfg_index = CFG_LAT_LINES;
  logic [CFG_W-1:0] cfg_data = '0;
  logic     req_valid = 1'b0;
  logic     req_stall;
  req_t     req_data = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  rsp_t     rsp_data;

  uv_sphere_mesh_generator u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req_valid(req_valid), .req_stall(req_stall),
    .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .rsp_data(rsp_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the two line-count registers
  logic [CFG_W-1:0] lat_reg = CFG_W'(LAT_RESET);
  logic [CFG_W-1:0] long_reg = CFG_W'(LONG_RESET);

  rsp_t mesh_answers[$];
  int   fail_count = 0;
  int   beats_seen = 0;
  int   vert_sent = 0;
  int   tri_sent = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  localparam longint ATAN_TBL [CORDIC_STEPS] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  // arithmetic shift rounds toward minus infinity, as floor shifts need
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // q16 angle in [0, 2pi) to q30 sine and cosine
  function automatic void q30_sincos(longint ang, output longint sn, output longint cs);
    logic   flip;
    longint xr, yr, zr, dx, dy;
    flip = 1'b0;
    xr = CORDIC_K;
    yr = 0;
    if (ang > ANG_HALF_PI && ang <= ANG_3HALF_PI) begin
      ang = ANG_PI - ang;
      flip = 1'b1;
    end else if (ang > ANG_3HALF_PI) begin
      ang = ang - ANG_2PI;
    end
    zr = ang;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shift(yr, i);
      dy = floor_shift(xr, i);
      if (zr >= 0) begin
        xr -= dx; yr += dy; zr -= ATAN_TBL[i];
      end else begin
        xr += dx; yr -= dy; zr += ATAN_TBL[i];
      end
    end
    sn = yr;
    cs = flip ? -xr : xr;
  endfunction

  // round half up, saturate to +-1.0 in q1.14
  function automatic logic [COORD_W-1:0] round_coord(longint v, int s);
    longint lim;
    lim = longint'(1) << COORD_FRAC_BITS;
    if (s > 0) v = floor_shift(v + (longint'(1) << (s - 1)), s);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[COORD_W-1:0];
  endfunction

  function automatic rsp_t sphere_answer(req_t q);
    rsp_t   r;
    longint lat, lg, nv, nt, it, ring, col, dp, p, y, sp, cp, sy, cy;
    longint a, b, c, u, band, rr, top, bot, t0, b0, t1, b1, l;
    r = '0;
    lat = lat_reg < MIN_LINES ? MIN_LINES : (lat_reg > MAX_LAT ? MAX_LAT : lat_reg);
    lg = long_reg < MIN_LINES ? MIN_LINES : (long_reg > MAX_LONG ? MAX_LONG : long_reg);
    nv = (lat - 2) * lg + 2;
    nt = (lat - 2) * lg * 2;
    it = q.item_number;
    if (q.operation == OP_VERTEX) begin
      if (it >= nv) begin
        r.status = 1'b1;
      end else if (it == 0) begin
        r.pos_z = round_coord(longint'(1) << 30, 30 - COORD_FRAC_BITS);
      end else if (it == nv - 1) begin
        r.pos_z = round_coord(-(longint'(1) << 30), 30 - COORD_FRAC_BITS);
      end else begin
        ring = (it - 1) / lg;
        col = (it - 1) % lg;
        dp = lat - 1;
        p = ((ring + 1) * ANG_P_STEP + dp) / (2 * dp);
        y = (col * ANG_Y_STEP + lg) / (2 * lg);
        q30_sincos(p, sp, cp);
        q30_sincos(y, sy, cy);
        r.pos_x = round_coord(sp * sy, 60 - COORD_FRAC_BITS);
        r.pos_y = round_coord(-(sp * cy), 60 - COORD_FRAC_BITS);
        r.pos_z = round_coord(cp, 30 - COORD_FRAC_BITS);
      end
      return r;
    end
    if (it >= nt) begin
      r.status = 1'b1;
      return r;
    end
    if (it < lg) begin
      // top cap fan around the north pole
      a = 0;
      if (it < lg - 1) begin b = it + 1; c = it + 2; end
      else begin b = lg; c = 1; end
    end else if (it < lg + (lat - 3) * lg * 2) begin
      // band quads, two triangles each, wrapping at the last column
      u = it - lg;
      band = u / (2 * lg);
      rr = u % (2 * lg);
      col = rr >> 1;
      top = band * lg;
      bot = (band + 1) * lg;
      t0 = top + col + 1;
      b0 = bot + col + 1;
      if (col < lg - 1) begin t1 = top + col + 2; b1 = bot + col + 2; end
      else begin t1 = top + 1; b1 = bot + 1; end
      if (rr[0] == 1'b0) begin a = t0; b = t1; c = b0; end
      else begin a = b0; b = t1; c = b1; end
    end else begin
      // bottom cap fan around the south pole
      l = it - lg - (lat - 3) * lg * 2;
      a = nv - 1;
      if (l < lg - 1) begin b = nv - 2 - l; c = nv - 3 - l; end
      else begin b = nv - 1 - lg; c = nv - 2; end
    end
    r.index_a = a[IDX_W-1:0];
    r.index_b = b[IDX_W-1:0];
    r.index_c = c[IDX_W-1:0];
    return r;
  endfunction

  // send one request beat, with random idle cycles ahead of it
  task automatic send_query(op_t op, int unsigned num);
    req_t q;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    q.operation = op;
    q.item_number = num[ITEM_W-1:0];
    req_valid <= 1'b1;
    req_data <= q;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    mesh_answers.push_back(sphere_answer(q));
    if (op == OP_VERTEX) vert_sent++;
    else tri_sent++;
  endtask

  // receiver stall and response checking
  always @(posedge clk) begin
    if (!rst) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      if (rsp_valid && !rsp_stall) begin
        rsp_t e;
        beats_seen++;
        if (mesh_answers.size() == 0) begin
          $error("response beat with nothing expected");
          fail_count++;
        end else begin
          e = mesh_answers.pop_front();
          if (rsp_data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, rsp_data.status); fail_count++;
          end
          if (rsp_data.index_a !== e.index_a) begin
            $error("index_a exp %0d got %0d", e.index_a, rsp_data.index_a); fail_count++;
          end
          if (rsp_data.index_b !== e.index_b) begin
            $error("index_b exp %0d got %0d", e.index_b, rsp_data.index_b); fail_count++;
          end
          if (rsp_data.index_c !== e.index_c) begin
            $error("index_c exp %0d got %0d", e.index_c, rsp_data.index_c); fail_count++;
          end
          if (rsp_data.pos_x !== e.pos_x) begin
            $error("pos_x exp %0d got %0d", e.pos_x, rsp_data.pos_x); fail_count++;
          end
          if (rsp_data.pos_y !== e.pos_y) begin
            $error("pos_y exp %0d got %0d", e.pos_y, rsp_data.pos_y); fail_count++;
          end
          if (rsp_data.pos_z !== e.pos_z) begin
            $error("pos_z exp %0d got %0d", e.pos_z, rsp_data.pos_z); fail_count++;
          end
        end
      end
    end
  end

  // wait for the pipeline to drain before touching registers
  task automatic drain;
    req_valid <= 1'b0;
    while (mesh_answers.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_lines(logic [CFG_W-1:0] lat_v, logic [CFG_W-1:0] long_v);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= CFG_LAT_LINES;
    cfg_data <= lat_v;
    @(posedge clk);
    cfg_index <= CFG_LONG_LINES;
    cfg_data <= long_v;
    @(posedge clk);
    cfg_write <= 1'b0;
    lat_reg = lat_v;
    long_reg = long_v;
  endtask

  // poles, field extremes, cap and band wrap corners, out of range numbers
  task automatic test_directed;
    int unsigned nv, nt;
    nv = 8 * 10 + 2;
    nt = 8 * 10 * 2;
    send_query(OP_VERTEX, 0);
    send_query(OP_VERTEX, 1);
    send_query(OP_VERTEX, 10);
    send_query(OP_VERTEX, nv - 2);
    send_query(OP_VERTEX, nv - 1);
    send_query(OP_VERTEX, nv);
    send_query(OP_VERTEX, 131071);
    send_query(OP_TRIANGLE, 0);
    send_query(OP_TRIANGLE, 9);
    send_query(OP_TRIANGLE, 10);
    send_query(OP_TRIANGLE, 29);
    send_query(OP_TRIANGLE, nt - 11);
    send_query(OP_TRIANGLE, nt - 1);
    send_query(OP_TRIANGLE, nt);
    send_query(OP_TRIANGLE, 131071);
  endtask

  // register extremes, including out-of-range values that clamp
  task automatic test_register_extremes;
    logic [CFG_W-1:0] lv [5] = '{0, 3, 256, 511, 257};
    logic [CFG_W-1:0] gv [5] = '{511, 0, 256, 3, 2};
    int unsigned nv, nt, la, lo;
    for (int k = 0; k < 5; k++) begin
      set_lines(lv[k], gv[k]);
      la = lv[k] < 3 ? 3 : (lv[k] > 256 ? 256 : lv[k]);
      lo = gv[k] < 3 ? 3 : (gv[k] > 256 ? 256 : gv[k]);
      nv = (la - 2) * lo + 2;
      nt = (la - 2) * lo * 2;
      send_query(OP_VERTEX, nv - 1);
      send_query(OP_VERTEX, nv - 2);
      send_query(OP_VERTEX, nv);
      send_query(OP_TRIANGLE, nt - 1);
      send_query(OP_TRIANGLE, lo - 1);
      send_query(OP_TRIANGLE, nt);
    end
  endtask

  // random queries, mostly in range, under a given idle pattern
  task automatic test_random(int count, int s_pct, int r_pct);
    int unsigned la, lo, nv, nt, num;
    op_t op;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 0) begin
        case ($urandom_range(3))
          0: set_lines(CFG_W'($urandom_range(3, 20)), CFG_W'($urandom_range(3, 20)));
          1: set_lines(CFG_W'($urandom_range(3, 256)), CFG_W'($urandom_range(3, 256)));
          2: set_lines(CFG_W'($urandom_range(0, 511)), CFG_W'($urandom_range(0, 511)));
          default: set_lines(CFG_W'(256), CFG_W'(256));
        endcase
      end
      la = lat_reg < 3 ? 3 : (lat_reg > 256 ? 256 : lat_reg);
      lo = long_reg < 3 ? 3 : (long_reg > 256 ? 256 : long_reg);
      nv = (la - 2) * lo + 2;
      nt = (la - 2) * lo * 2;
      op = op_t'($urandom_range(1));
      if ($urandom_range(9) == 0) num = $urandom_range(131071);
      else num = $urandom_range((op == OP_VERTEX ? nv : nt) - 1);
      send_query(op, num);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random(480, 8, 87);
    test_random(480, 87, 8);
    test_random(480, 0, 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    $display("covered %0d vertex and %0d triangle queries, %0d response beats checked",
             vert_sent, tri_sent, beats_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #4ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
